// File: hw/rtl/tbc_pkg.sv
`timescale 1ns / 1ps

package tbc_pkg;

   localparam int PIX_W       = 8;
   localparam int MONO_W      = 8;
   localparam int CENT_W      = 12;
   localparam int REQ_DATA_W  = 3 * PIX_W;
   localparam int RSP_DATA_W  = MONO_W + 2 * CENT_W;

   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 13;
   localparam int THR_W       = 8;
   localparam int DIM_W       = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_GRAY_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT   = 2'd2;

   localparam logic [THR_W-1:0] THR_RESET    = 8'd128;
   localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

   localparam logic [MONO_W-1:0] MONO_BRIGHT = 8'hFF;
   localparam logic [MONO_W-1:0] MONO_DARK   = 8'h00;

   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam int QUEUE_DEPTH    = 4;

   typedef struct packed {
      logic done;
      logic bright;
   } job_flags_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // bits of a position counter
   function automatic int pos_w(input int max_dim);
      return $clog2(max_dim);
   endfunction

   // quotient bits of the centroid divider, enough for either axis
   function automatic int step_w(input int max_w, input int max_h);
      return (pos_w(max_w) > pos_w(max_h)) ? pos_w(max_w) : pos_w(max_h);
   endfunction

   function automatic int count_w(input int max_w, input int max_h);
      return pos_w(max_w) + pos_w(max_h) + 1;
   endfunction

   function automatic int sum_w(input int max_w, input int max_h);
      return step_w(max_w, max_h) + count_w(max_w, max_h);
   endfunction

   function automatic int job_w(input int max_w, input int max_h);
      return $bits(job_flags_type) + pos_w(max_w) + pos_w(max_h)
             + count_w(max_w, max_h) + 2 * sum_w(max_w, max_h);
   endfunction

endpackage

// File: hw/rtl/tbc_queue.sv
`timescale 1ns / 1ps

module tbc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = tbc_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          push_data,
   input  logic                      pop,
   output logic [WIDTH-1:0]          pop_data,
   output tbc_pkg::queue_status_type status
);
   import tbc_pkg::*;

   localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.full  = (fill_ff == CNTW'(DEPTH));
   assign status.empty = (fill_ff == '0);

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNTW'(DEPTH))
      else $error("queue fill beyond depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("item taken from empty queue");

endmodule

// File: hw/rtl/tbc_front.sv
`timescale 1ns / 1ps

module tbc_front #(
   parameter int MAX_WIDTH  = tbc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = tbc_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wen,
   input  logic [tbc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [tbc_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [tbc_pkg::REQ_DATA_W-1:0]        req_tdata,
   input  tbc_pkg::queue_status_type             status,
   output logic                                  push,
   output logic [tbc_pkg::job_w(MAX_WIDTH, MAX_HEIGHT)-1:0] job_data
);
   import tbc_pkg::*;

   localparam int PW   = pos_w(MAX_WIDTH);
   localparam int PH   = pos_w(MAX_HEIGHT);
   localparam int PW1  = PW + 1;
   localparam int PH1  = PH + 1;
   localparam int CW   = count_w(MAX_WIDTH, MAX_HEIGHT);
   localparam int SUMW = sum_w(MAX_WIDTH, MAX_HEIGHT);
   localparam int WCW  = (PW1 > DIM_W) ? PW1 : DIM_W;
   localparam int HCW  = (PH1 > DIM_W) ? PH1 : DIM_W;

   logic [THR_W-1:0] thr_ff;
   logic [DIM_W-1:0] width_ff;
   logic [DIM_W-1:0] height_ff;

   logic [PW-1:0]   col_pos_ff, col_pos_in;
   logic [PH-1:0]   row_pos_ff, row_pos_in;
   logic [SUMW-1:0] col_sum_ff, col_sum_in;
   logic [SUMW-1:0] row_sum_ff, row_sum_in;
   logic [CW-1:0]   count_ff, count_in;

   logic [PIX_W-1:0] red, green, blue;
   logic [9:0]       rgb_sum;
   logic [9:0]       rgb_limit;
   logic             bright;
   logic [WCW-1:0]   width_wide;
   logic [HCW-1:0]   height_wide;
   logic [PW1-1:0]   width_eff;
   logic [PH1-1:0]   height_eff;
   logic             last_col;
   logic             last_row;
   logic [SUMW-1:0]  col_sum_next;
   logic [SUMW-1:0]  row_sum_next;
   logic [CW-1:0]    count_next;
   job_flags_type    flags;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= THR_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_GRAY_THRESHOLD: thr_ff    <= csr_wdata[THR_W-1:0];
            CSR_FRAME_WIDTH:    width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_FRAME_HEIGHT:   height_ff <= csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   assign {blue, green, red} = req_tdata;

   always_comb begin
      // gray > thr  is the same as  r + g + b > 3 * thr + 2
      rgb_sum   = 10'(red) + 10'(green) + 10'(blue);
      rgb_limit = 10'(thr_ff) + {1'b0, thr_ff, 1'b0} + 10'd2;
      bright    = rgb_sum > rgb_limit;

      width_wide  = WCW'(width_ff);
      height_wide = HCW'(height_ff);
      priority if (width_wide == '0)                 width_eff = PW1'(1);
      else if (width_wide > WCW'(MAX_WIDTH))         width_eff = PW1'(MAX_WIDTH);
      else                                           width_eff = PW1'(width_wide);
      priority if (height_wide == '0)                height_eff = PH1'(1);
      else if (height_wide > HCW'(MAX_HEIGHT))       height_eff = PH1'(MAX_HEIGHT);
      else                                           height_eff = PH1'(height_wide);

      // a counter past a shrunk frame counts as on its last column or row
      last_col = {1'b0, col_pos_ff} >= (width_eff - 1'b1);
      last_row = {1'b0, row_pos_ff} >= (height_eff - 1'b1);

      col_sum_next = col_sum_ff + (bright ? SUMW'(col_pos_ff) : '0);
      row_sum_next = row_sum_ff + (bright ? SUMW'(row_pos_ff) : '0);
      count_next   = count_ff + CW'(bright);

      flags.bright = bright;
      flags.done   = last_col && last_row;

      req_tready = !status.full;
      push       = req_tvalid && req_tready;
      job_data   = {row_sum_next, col_sum_next, count_next,
                    PH'(height_eff >> 1), PW'(width_eff >> 1), flags};

      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      col_sum_in = col_sum_ff;
      row_sum_in = row_sum_ff;
      count_in   = count_ff;
      if (push) begin
         col_sum_in = col_sum_next;
         row_sum_in = row_sum_next;
         count_in   = count_next;
         if (last_col) begin
            col_pos_in = '0;
            if (last_row) begin
               row_pos_in = '0;
               col_sum_in = '0;
               row_sum_in = '0;
               count_in   = '0;
            end else begin
               row_pos_in = row_pos_ff + 1'b1;
            end
         end else begin
            col_pos_in = col_pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
         col_sum_ff <= '0;
         row_sum_ff <= '0;
         count_ff   <= '0;
      end else begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
         col_sum_ff <= col_sum_in;
         row_sum_ff <= row_sum_in;
         count_ff   <= count_in;
      end
   end

   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      (32'(col_pos_ff) < MAX_WIDTH) && (32'(row_pos_ff) < MAX_HEIGHT))
      else $error("position counter beyond largest frame");

endmodule

// File: hw/rtl/tbc_back.sv
`timescale 1ns / 1ps

module tbc_back #(
   parameter int MAX_WIDTH  = tbc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = tbc_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tbc_pkg::queue_status_type             status,
   input  logic [tbc_pkg::job_w(MAX_WIDTH, MAX_HEIGHT)-1:0] job_data,
   output logic                                  pop,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [tbc_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                  rsp_tlast
);
   import tbc_pkg::*;

   localparam int PW    = pos_w(MAX_WIDTH);
   localparam int PH    = pos_w(MAX_HEIGHT);
   localparam int S     = step_w(MAX_WIDTH, MAX_HEIGHT);
   localparam int CW    = count_w(MAX_WIDTH, MAX_HEIGHT);
   localparam int SUMW  = sum_w(MAX_WIDTH, MAX_HEIGHT);
   localparam int STEPW = $clog2(S + 1);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_DIVIDE = 1'b1;

   logic [SUMW-1:0] job_row_sum, job_col_sum;
   logic [CW-1:0]   job_count;
   logic [PH-1:0]   job_half_h;
   logic [PW-1:0]   job_half_w;
   job_flags_type   job_flags;

   logic             state_ff, state_in;
   logic [STEPW-1:0] step_ff, step_in;
   logic             rsp_tvalid_ff, rsp_tvalid_in;
   logic [MONO_W-1:0] mono_ff, mono_in;
   logic [CENT_W-1:0] cent_col_ff, cent_col_in;
   logic [CENT_W-1:0] cent_row_ff, cent_row_in;
   logic             tlast_ff, tlast_in;
   logic             bright_ff, bright_in;
   logic [CW-1:0]    den_ff, den_in;
   logic [CW-1:0]    rem_col_ff, rem_col_in;
   logic [CW-1:0]    rem_row_ff, rem_row_in;
   logic [S-1:0]     num_col_ff, num_col_in;
   logic [S-1:0]     num_row_ff, num_row_in;

   logic          out_free;
   logic          need_div;
   logic          load_out;
   logic [CW:0]   trial_col, trial_row, den_ext;
   logic          q_col, q_row;

   assign {job_row_sum, job_col_sum, job_count, job_half_h, job_half_w, job_flags} = job_data;

   always_comb begin
      out_free = !rsp_tvalid_ff || rsp_tready;
      need_div = job_flags.done && (job_count != '0);

      // one restoring step per cycle; quotient bits shift into num
      den_ext   = {1'b0, den_ff};
      trial_col = {rem_col_ff, num_col_ff[S-1]};
      trial_row = {rem_row_ff, num_row_ff[S-1]};
      q_col     = trial_col >= den_ext;
      q_row     = trial_row >= den_ext;

      state_in    = state_ff;
      step_in     = step_ff;
      bright_in   = bright_ff;
      den_in      = den_ff;
      rem_col_in  = rem_col_ff;
      rem_row_in  = rem_row_ff;
      num_col_in  = num_col_ff;
      num_row_in  = num_row_ff;
      mono_in     = mono_ff;
      cent_col_in = cent_col_ff;
      cent_row_in = cent_row_ff;
      tlast_in    = tlast_ff;
      load_out    = 1'b0;
      pop         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!status.empty && out_free) begin
               pop = 1'b1;
               if (need_div) begin
                  state_in   = ST_DIVIDE;
                  step_in    = STEPW'(S);
                  bright_in  = job_flags.bright;
                  den_in     = job_count;
                  rem_col_in = CW'(job_col_sum >> S);
                  rem_row_in = CW'(job_row_sum >> S);
                  num_col_in = S'(job_col_sum);
                  num_row_in = S'(job_row_sum);
               end else begin
                  load_out    = 1'b1;
                  mono_in     = job_flags.bright ? MONO_BRIGHT : MONO_DARK;
                  tlast_in    = job_flags.done;
                  cent_col_in = job_flags.done ? CENT_W'(job_half_w) : '0;
                  cent_row_in = job_flags.done ? CENT_W'(job_half_h) : '0;
               end
            end
         end
         ST_DIVIDE: begin
            if (step_ff != '0) begin
               step_in    = step_ff - 1'b1;
               rem_col_in = q_col ? CW'(trial_col - den_ext) : trial_col[CW-1:0];
               rem_row_in = q_row ? CW'(trial_row - den_ext) : trial_row[CW-1:0];
               num_col_in = (num_col_ff << 1) | S'(q_col);
               num_row_in = (num_row_ff << 1) | S'(q_row);
            end else if (out_free) begin
               state_in    = ST_IDLE;
               load_out    = 1'b1;
               mono_in     = bright_ff ? MONO_BRIGHT : MONO_DARK;
               tlast_in    = 1'b1;
               cent_col_in = CENT_W'(num_col_ff);
               cent_row_in = CENT_W'(num_row_ff);
            end
         end
         default: ;
      endcase

      if (load_out) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      bright_ff   <= bright_in;
      den_ff      <= den_in;
      rem_col_ff  <= rem_col_in;
      rem_row_ff  <= rem_row_in;
      num_col_ff  <= num_col_in;
      num_row_ff  <= num_row_in;
      mono_ff     <= mono_in;
      cent_col_ff <= cent_col_in;
      cent_row_ff <= cent_row_in;
      tlast_ff    <= tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tlast  = tlast_ff;
   assign rsp_tdata  = {cent_row_ff, cent_col_ff, mono_ff};

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (den_ff != '0))
      else $error("centroid divide with zero count");

   a_centroid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !tlast_ff) |-> (cent_col_ff == '0) && (cent_row_ff == '0))
      else $error("centroid fields set outside frame end");

endmodule

// File: hw/rtl/threshold_blob_centroid.sv
`timescale 1ns / 1ps

// Channel   Ports              Contents
// req       req_t*             pixel in, raster order
// rsp       rsp_t*             mono pixel, frame end, centroid
// csr       csr_*              threshold, frame width, frame height
//
// The front takes one pixel a clock while the queue has room; the queue holds each
// accepted pixel until the back, idle with its output free, pops it, and its result
// is offered from the output register. A frame's last pixel with bright pixels holds
// the back while it works out S = max(clog2 MAX_WIDTH, clog2 MAX_HEIGHT) (12 at defaults)
// quotient bits, one quotient bit a cycle for column and row side by side. The four-item
// queue takes the pixels that follow, then req_tready drops until the divide ends. Reset
// is synchronous; no clearing pass. Either side may stall.

module threshold_blob_centroid #(
   parameter int MAX_WIDTH  = tbc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = tbc_pkg::DEF_MAX_HEIGHT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wen,
   input  logic [tbc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tbc_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [tbc_pkg::REQ_DATA_W-1:0] req_tdata,  // red, green, blue
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [tbc_pkg::RSP_DATA_W-1:0] rsp_tdata,  // mono_pixel, centroid_col, centroid_row
   output logic                           rsp_tlast   // frame_done
);
   import tbc_pkg::*;

   localparam int JOBW = job_w(MAX_WIDTH, MAX_HEIGHT);

   logic             push;
   logic             pop;
   logic [JOBW-1:0]  push_data;
   logic [JOBW-1:0]  pop_data;
   queue_status_type status;

   tbc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .status     (status),
      .push       (push),
      .job_data   (push_data)
   );

   tbc_queue #(
      .WIDTH (JOBW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (status)
   );

   tbc_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .status     (status),
      .job_data   (pop_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: dv/threshold_blob_centroid_test.sv
`timescale 1ns / 1ps

module threshold_blob_centroid_test;
   import tbc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int IDLE_PCT      = 17;
   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_PIXELS = 840;
   localparam int HOLD_CYCLES   = 120;

   typedef struct {
      logic [MONO_W-1:0] mono;
      logic              done;
      logic [CENT_W-1:0] col;
      logic [CENT_W-1:0] row;
   } pixel_result_type;

   class centroid_scoreboard;
      logic [THR_W-1:0] threshold;
      logic [DIM_W-1:0] width_reg;
      logic [DIM_W-1:0] height_reg;
      int unsigned      col_pos;
      int unsigned      row_pos;
      longint unsigned  col_sum;
      longint unsigned  row_sum;
      int unsigned      bright_count;
      pixel_result_type expected_q[$];
      int unsigned      errors;
      int unsigned      pixels;
      int unsigned      results_seen;
      int unsigned      frames;
      int unsigned      empty_frames;

      function new();
         threshold    = THR_RESET;
         width_reg    = WIDTH_RESET;
         height_reg   = HEIGHT_RESET;
         col_pos      = 0;
         row_pos      = 0;
         col_sum      = 0;
         row_sum      = 0;
         bright_count = 0;
         errors       = 0;
         pixels       = 0;
         results_seen = 0;
         frames       = 0;
         empty_frames = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report_mismatch(input string what, input longint got, input longint want);
         errors++;
         $display("%0t: result %0d: %s: got %0d, want %0d", $time, results_seen, what,
                  got, want);
      endtask

      function void write_register(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_GRAY_THRESHOLD: threshold  = val[THR_W-1:0];
            CSR_FRAME_WIDTH:    width_reg  = val[DIM_W-1:0];
            CSR_FRAME_HEIGHT:   height_reg = val[DIM_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_pixel(input logic [REQ_DATA_W-1:0] px);
         int unsigned      w;
         int unsigned      h;
         int unsigned      gray;
         bit               bright;
         pixel_result_type res;
         w = (width_reg == 0) ? 1 :
             ((width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(width_reg));
         h = (height_reg == 0) ? 1 :
             ((height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(height_reg));
         gray = (int'(px[PIX_W-1:0]) + int'(px[2*PIX_W-1:PIX_W])
                 + int'(px[3*PIX_W-1:2*PIX_W])) / 3;
         bright   = gray > threshold;
         res.mono = bright ? MONO_BRIGHT : MONO_DARK;
         res.done = 1'b0;
         res.col  = '0;
         res.row  = '0;
         if (bright) begin
            col_sum += col_pos;
            row_sum += row_pos;
            bright_count++;
         end
         // a counter past a shrunken size counts as on the last column or row
         if (col_pos >= w - 1) begin
            col_pos = 0;
            if (row_pos >= h - 1) begin
               res.done = 1'b1;
               frames++;
               if (bright_count == 0) begin
                  res.col = CENT_W'(w / 2);
                  res.row = CENT_W'(h / 2);
                  empty_frames++;
               end else begin
                  res.col = CENT_W'(col_sum / bright_count);
                  res.row = CENT_W'(row_sum / bright_count);
               end
               row_pos      = 0;
               col_sum      = 0;
               row_sum      = 0;
               bright_count = 0;
            end else begin
               row_pos++;
            end
         end else begin
            col_pos++;
         end
         pixels++;
         expected_q.push_back(res);
      endfunction

      task check_result(input logic [RSP_DATA_W-1:0] data, input logic frame_end);
         pixel_result_type want;
         if (expected_q.size() == 0) begin
            report_mismatch("result with no pixel outstanding", data, 0);
         end else begin
            want = expected_q.pop_front();
            if (data[MONO_W-1:0] !== want.mono)
               report_mismatch("mono_pixel", data[MONO_W-1:0], want.mono);
            if (frame_end !== want.done)
               report_mismatch("frame_done", frame_end, want.done);
            if (data[MONO_W+CENT_W-1:MONO_W] !== want.col)
               report_mismatch("centroid_col", data[MONO_W+CENT_W-1:MONO_W], want.col);
            if (data[RSP_DATA_W-1:MONO_W+CENT_W] !== want.row)
               report_mismatch("centroid_row", data[RSP_DATA_W-1:MONO_W+CENT_W], want.row);
         end
         results_seen++;
      endtask
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_wen    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   centroid_scoreboard tracker;
   bit                 steady;
   bit                 hold_request;
   int unsigned        hold_left;
   int unsigned        quiet_cycles;
   int unsigned        settings_used;
   logic [THR_W-1:0]   cur_thr = THR_RESET;

   threshold_blob_centroid u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   // register writes, pixels and results in edge order, all from one process
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wen) tracker.write_register(csr_index, csr_wdata);
         if (req_tvalid && req_tready) tracker.note_pixel(req_tdata);
         if (rsp_tvalid && rsp_tready) tracker.check_result(rsp_tdata, rsp_tlast);
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (hold_request) begin
         // hold off long enough for the block to fill and stall its input
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if (reset || csr_wen || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("threshold_blob_centroid verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_pixel(input logic [REQ_DATA_W-1:0] px);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_rgb(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                           input logic [PIX_W-1:0] b);
      send_pixel({b, g, r});
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   task automatic configure(input logic [THR_W-1:0] thr, input logic [DIM_W-1:0] w,
                            input logic [DIM_W-1:0] h, input bit poke_spare);
      csr_wen   <= 1'b1;
      csr_index <= CSR_GRAY_THRESHOLD;
      csr_wdata <= CSR_DATA_W'(thr);
      @(posedge clock);
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      if (poke_spare) begin
         // unused index: must leave every register alone
         csr_index <= CSR_SPARE;
         csr_wdata <= CSR_DATA_W'($urandom);
         @(posedge clock);
      end
      csr_wen <= 1'b0;
      cur_thr = thr;
      settings_used++;
   endtask

   function automatic logic [REQ_DATA_W-1:0] make_pixel(input logic [THR_W-1:0] thr,
                                                         input bit dark_only);
      int unsigned    kind;
      int             v;
      logic [PIX_W-1:0] r;
      logic [PIX_W-1:0] g;
      logic [PIX_W-1:0] b;
      kind = dark_only ? 4 : $urandom_range(0, 9);
      if (kind <= 3) begin
         r = PIX_W'($urandom_range(0, 255));
         g = PIX_W'($urandom_range(0, 255));
         b = PIX_W'($urandom_range(0, 255));
      end else if (kind <= 5) begin
         r = PIX_W'($urandom_range(0, thr));
         g = PIX_W'($urandom_range(0, thr));
         b = PIX_W'($urandom_range(0, thr));
      end else if (kind <= 7) begin
         r = PIX_W'($urandom_range(thr, 255));
         g = PIX_W'($urandom_range(thr, 255));
         b = PIX_W'($urandom_range(thr, 255));
      end else begin
         // gray one below, at or one above the threshold (clamped to 0..253), with a truncated remainder
         v = int'(thr) + int'($urandom_range(0, 2)) - 1;
         if (v < 0) v = 0;
         if (v > 253) v = 253;
         r = PIX_W'(v);
         g = PIX_W'(v);
         b = PIX_W'(v + int'($urandom_range(0, 2)));
      end
      return {b, g, r};
   endfunction

   initial begin
      int unsigned      random_sent;
      int unsigned      n;
      int unsigned      ww;
      int unsigned      hh;
      int unsigned      pick;
      logic [THR_W-1:0] thr;
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
      bit               dark_only;

      tracker = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: threshold 128, 640 wide, so these stay on row 0
      send_rgb(8'd255, 8'd255, 8'd255);
      send_rgb(8'd0, 8'd0, 8'd0);
      send_rgb(8'd128, 8'd128, 8'd128);
      send_rgb(8'd129, 8'd129, 8'd129);
      send_rgb(8'd128, 8'd128, 8'd130);
      send_rgb(8'd129, 8'd129, 8'd130);
      send_rgb(8'd255, 8'd0, 8'd0);
      send_rgb(8'd255, 8'd255, 8'd0);
      drain();

      // shrink mid-frame: column 8 is now past the last column of a 4x2 frame
      configure(8'd128, 13'd4, 13'd2, 1'b1);
      send_rgb(8'd0, 8'd0, 8'd255);
      send_rgb(8'd200, 8'd100, 8'd50);
      send_rgb(8'd170, 8'd170, 8'd171);
      send_rgb(8'd1, 8'd2, 8'd3);
      send_rgb(8'd0, 8'd255, 8'd255);
      drain();

      // frame with nothing bright falls back to the centre
      configure(8'd128, 13'd3, 13'd1, 1'b0);
      send_rgb(8'd10, 8'd20, 8'd30);
      send_rgb(8'd128, 8'd128, 8'd128);
      send_rgb(8'd0, 8'd0, 8'd0);
      drain();

      // zero sizes act as 1x1: every pixel ends a frame
      configure(8'd0, 13'd0, 13'd0, 1'b0);
      send_rgb(8'd0, 8'd0, 8'd0);
      send_rgb(8'd0, 8'd0, 8'd2);
      send_rgb(8'd1, 8'd1, 8'd1);
      drain();

      // top threshold: nothing can exceed it
      configure(8'd255, 13'd2, 13'd1, 1'b0);
      send_rgb(8'd255, 8'd255, 8'd255);
      send_rgb(8'd254, 8'd255, 8'd255);
      drain();

      // oversize registers: sizes clamp to the largest frame, then shrink to close the frame
      configure(8'($urandom_range(0, 255)), 13'h1FFF, 13'd4097, 1'b0);
      repeat (40) send_pixel(make_pixel(cur_thr, 1'b0));
      drain();
      configure(cur_thr, 13'd8, 13'd1, 1'b0);
      repeat (9) send_pixel(make_pixel(cur_thr, 1'b0));
      drain();

      // receiver holds off while pixels keep coming, so the input stalls
      configure(8'd100, 13'd8, 13'd4, 1'b0);
      hold_request = 1'b1;
      repeat (40) send_pixel(make_pixel(cur_thr, 1'b0));
      drain();

      random_sent = 0;
      while (random_sent < RANDOM_PIXELS) begin
         pick = $urandom_range(0, 9);
         thr  = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(0, 255));
         w = DIM_W'($urandom_range(1, 12));
         h = DIM_W'($urandom_range(1, 6));
         pick = $urandom_range(0, 9);
         if (pick == 0) w = '0;
         if (pick == 1) h = '0;
         dark_only = ($urandom_range(0, 7) == 0);
         configure(thr, w, h, $urandom_range(0, 3) == 0);
         ww = (w == 0) ? 1 : int'(w);
         hh = (h == 0) ? 1 : int'(h);
         // mostly whole frames; now and then a partial one carries into the next setting
         if ($urandom_range(0, 5) == 0) n = $urandom_range(1, 2 * ww * hh);
         else n = $urandom_range(1, 3) * ww * hh;
         if (n > RANDOM_PIXELS - random_sent) n = RANDOM_PIXELS - random_sent;
         repeat (n) begin
            steady = (random_sent >= 300) && (random_sent < 500);
            if (random_sent == 100 || random_sent == 700) hold_request = 1'b1;
            send_pixel(make_pixel(thr, dark_only));
            random_sent++;
         end
         steady = 1'b0;
         drain();
      end

      repeat (30) @(posedge clock);
      if (tracker.pending() != 0)
         tracker.report_mismatch("expected results never arrived", 0, tracker.pending());

      $display("Covered %0d pixels, %0d finished frames (%0d with no bright pixel), %0d settings",
               tracker.pixels, tracker.frames, tracker.empty_frames, settings_used);
      $display("including zero and oversize sizes, sizes changed mid-frame and a held output");
      if (tracker.errors == 0) begin
         $display("threshold_blob_centroid verification clean");
      end else begin
         $display("threshold_blob_centroid verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/tbc_pkg.sv
hw/rtl/tbc_queue.sv
hw/rtl/tbc_front.sv
hw/rtl/tbc_back.sv
hw/rtl/threshold_blob_centroid.sv
dv/threshold_blob_centroid_test.sv
